// ----- hdl/ctu_pkg.sv -----
package ctu_pkg;

    localparam int unsigned YearFirst = 1970;
    localparam int unsigned YearLast = 9999;
    // days from year 1 through the end of 1969
    localparam logic [22:0] EpochDays = 23'd719162;
    localparam logic [16:0] DaySeconds = 17'd86400;
    localparam logic [12:0] Recip100 = 13'd5243;   // 2^19 / 100, rounded up
    localparam int unsigned Recip100Shift = 19;

    typedef struct packed {
        logic        rej;
        logic [13:0] y;       // year - 1
        logic [6:0]  q100;    // (year - 1) / 100
        logic [8:0]  doy;     // day of year, from 0
        logic [16:0] tod;     // seconds of the day
        logic [9:0]  millis;
    } t_item;

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // floor(v / 100), exact for v below 10000
    function automatic logic [6:0] div100(input logic [13:0] v);
        logic [26:0] p;
        p = {13'd0, v} * {14'd0, Recip100};
        return p[Recip100Shift +: 7];
    endfunction

endpackage

// ----- hdl/ctu_front.sv -----
module ctu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [13:0]        i_year,
    input  logic [6:0]         i_month,
    input  logic [6:0]         i_day,
    input  logic [6:0]         i_hour,
    input  logic [6:0]         i_minute,
    input  logic [6:0]         i_second,
    input  logic [9:0]         i_millis,
    input  logic               i_full,
    output logic               o_push,
    output logic               o_ready,
    output ctu_pkg::t_item     o_item
);

    logic           r_valid;
    ctu_pkg::t_item r_item;
    ctu_pkg::t_item n_item;

    logic        bad;
    logic [13:0] ym1;
    logic [6:0]  qy;
    logic [13:0] ry;
    logic        leap;
    logic [3:0]  midx;
    logic [8:0]  adj;
    logic [16:0] hsec;
    logic [16:0] msec;

    always_comb begin
        bad = (i_year < 14'(ctu_pkg::YearFirst)) || (i_year > 14'(ctu_pkg::YearLast))
            || (i_month < 7'd1) || (i_month > 7'd12)
            || (i_day < 7'd1) || (i_day > 7'd31)
            || (i_hour > 7'd23) || (i_minute > 7'd59) || (i_second > 7'd59)
            || (i_millis > 10'd999);
        ym1 = i_year - 14'd1;
        qy = ctu_pkg::div100(i_year);
        ry = i_year - 14'({7'd0, qy} * 14'd100);
        leap = ((i_year[1:0] == 2'd0) && (ry != 14'd0))
            || ((ry == 14'd0) && (qy[1:0] == 2'd0));
        midx = i_month[3:0] - 4'd1;
        adj = {8'd0, (i_month > 7'd2) && leap};
        hsec = {12'd0, i_hour[4:0]} * 17'd3600;
        msec = {11'd0, i_minute[5:0]} * 17'd60;
        n_item.rej = bad;
        n_item.y = ym1;
        n_item.q100 = ctu_pkg::div100(ym1);
        n_item.doy = ctu_pkg::month_start(midx) + adj + {2'd0, i_day} - 9'd1;
        n_item.tod = hsec + msec + {11'd0, i_second[5:0]};
        n_item.millis = i_millis;
    end

    assign o_push = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_take;
        end
        if (i_take && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hdl/ctu_fifo.sv -----
module ctu_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ctu_pkg::t_item     i_item,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output ctu_pkg::t_item     o_item
);

    ctu_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           pop;

    assign o_full = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_item = r_mem[r_rp];
    assign pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- hdl/ctu_back.sv -----
module ctu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ctu_pkg::t_item     i_item,
    output logic               o_strobe,
    output logic [47:0]        o_epoch_millis,
    output logic               o_rejected
);

    // stage valids and payload
    logic [4:0]  r_v;
    logic [4:0]  r_rej;
    logic [21:0] r_days;
    logic [38:0] r_dsec;
    logic [38:0] r_secs;
    logic [47:0] r_ms;
    logic [16:0] r_tod1;
    logic [16:0] r_tod2;
    logic [9:0]  r_ml [4];
    logic [47:0] r_out;

    logic [22:0] n_days;
    logic [13:0] y;
    logic [6:0]  q;

    always_comb begin
        y = i_item.y;
        q = i_item.q100;
        n_days = {9'd0, y} * 23'd365 + {11'd0, y[13:2]} - {16'd0, q} + {18'd0, q[6:2]}
            + {14'd0, i_item.doy} - ctu_pkg::EpochDays;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 5'd0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
        r_rej <= {r_rej[3:0], i_item.rej};
        r_days <= n_days[21:0];
        r_tod1 <= i_item.tod;
        r_ml[0] <= i_item.millis;
        r_dsec <= {17'd0, r_days} * {22'd0, ctu_pkg::DaySeconds};
        r_tod2 <= r_tod1;
        r_ml[1] <= r_ml[0];
        r_secs <= r_dsec + {22'd0, r_tod2};
        r_ml[2] <= r_ml[1];
        r_ms <= 48'({9'd0, r_secs} * 48'd1000);
        r_ml[3] <= r_ml[2];
        r_out <= r_rej[3] ? 48'd0 : r_ms + {38'd0, r_ml[3]};
    end

    assign o_strobe = r_v[4];
    assign o_epoch_millis = r_out;
    assign o_rejected = r_rej[4];

endmodule

// ----- hdl/calendar_to_unix_millis.sv -----
// UTC calendar date and time to milliseconds since 1970-01-01 00:00:00.
// Input: an item is taken at a rising edge with start high and busy low;
// i_year, i_month, i_day, i_hour, i_minute, i_second and i_millis are
// sampled at that edge. Fields out of range give o_rejected high and a
// zero o_epoch_millis; the day is checked against 31 only.
// Output: each result shows for one cycle with o_strobe high. The receiver
// cannot hold results off.
// Path: the front register, the two-entry queue and the five-stage back
// pipeline lie between the accepting edge and the edge that takes the result.
// Throughput: one item per cycle. The back pipeline never stalls, so the
// queue drains every cycle and busy stays low in normal use; it rises only
// if the queue were full.
// Reset: synchronous, active low; drops every item in flight, no result
// follows for items taken before reset.
module calendar_to_unix_millis (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] i_year,
    input  logic [6:0]  i_month,
    input  logic [6:0]  i_day,
    input  logic [6:0]  i_hour,
    input  logic [6:0]  i_minute,
    input  logic [6:0]  i_second,
    input  logic [9:0]  i_millis,
    output logic        o_strobe,
    output logic [47:0] o_epoch_millis,
    output logic        o_rejected
);

    logic           ready;
    logic           push;
    logic           full;
    logic           empty;
    ctu_pkg::t_item f_item;
    ctu_pkg::t_item q_item;

    assign busy = !ready;

    ctu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (start),
        .i_year   (i_year),
        .i_month  (i_month),
        .i_day    (i_day),
        .i_hour   (i_hour),
        .i_minute (i_minute),
        .i_second (i_second),
        .i_millis (i_millis),
        .i_full   (full),
        .o_push   (push),
        .o_ready  (ready),
        .o_item   (f_item)
    );

    ctu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (1'b1),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    ctu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (!empty),
        .i_item         (q_item),
        .o_strobe       (o_strobe),
        .o_epoch_millis (o_epoch_millis),
        .o_rejected     (o_rejected)
    );

endmodule

// ----- sim/tb_calendar_to_unix_millis.sv -----
`timescale 1ns / 100ps

module tb_calendar_to_unix_millis;

    localparam int unsigned HalfPeriod = 10;
    localparam int unsigned DrainLimit = 2000;
    localparam int unsigned TailCycles = 20;
    localparam longint unsigned MsPerSec = 1000;
    localparam longint unsigned SecPerMin = 60;
    localparam longint unsigned SecPerHour = 3600;
    localparam longint unsigned SecPerDay = 86400;
    localparam int unsigned MonthStart [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [9:0]  millis;
    } t_date_beat;

    typedef struct packed {
        logic [47:0] epoch_millis;
        logic        rejected;
    } t_stamp;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [13:0] i_year;
    logic [6:0]  i_month;
    logic [6:0]  i_day;
    logic [6:0]  i_hour;
    logic [6:0]  i_minute;
    logic [6:0]  i_second;
    logic [9:0]  i_millis;
    logic        o_strobe;
    logic [47:0] o_epoch_millis;
    logic        o_rejected;

    t_stamp pending_stamps[$];
    int     err_count = 0;
    bit     gaps_on = 1'b1;

    calendar_to_unix_millis u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day          (i_day),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_second       (i_second),
        .i_millis       (i_millis),
        .o_strobe       (o_strobe),
        .o_epoch_millis (o_epoch_millis),
        .o_rejected     (o_rejected)
    );

    always begin
        i_clk = 1'b1;
        #(HalfPeriod);
        i_clk = 1'b0;
        #(HalfPeriod);
    end

    function automatic bit leap_year(input longint unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days from year 1 through the end of year y
    function automatic longint unsigned days_to_year_end(input longint unsigned y);
        return 365 * y + y / 4 - y / 100 + y / 400;
    endfunction

    function automatic t_stamp predict_stamp(input t_date_beat b);
        longint unsigned y;
        longint unsigned days;
        longint unsigned secs;
        t_stamp r;
        y = b.year;
        r = '0;
        if (b.year < ctu_pkg::YearFirst || b.year > ctu_pkg::YearLast ||
            b.month < 1 || b.month > 12 ||
            b.day < 1 || b.day > 31 || b.hour > 23 || b.minute > 59 ||
            b.second > 59 || b.millis > 999) begin
            r.rejected = 1'b1;
            return r;
        end
        days = days_to_year_end(y - 1) - days_to_year_end(ctu_pkg::YearFirst - 1);
        days += MonthStart[b.month - 1];
        if (b.month > 2 && leap_year(y)) begin
            days += 1;
        end
        days += b.day - 1;
        secs = days * SecPerDay + b.hour * SecPerHour + b.minute * SecPerMin + b.second;
        r.epoch_millis = 48'(secs * MsPerSec + b.millis);
        return r;
    endfunction

    function automatic t_date_beat mk_date(input int y, input int mo, input int d,
                                           input int h, input int mi, input int s,
                                           input int ms);
        t_date_beat b;
        b.year = 14'(y);
        b.month = 7'(mo);
        b.day = 7'(d);
        b.hour = 7'(h);
        b.minute = 7'(mi);
        b.second = 7'(s);
        b.millis = 10'(ms);
        return b;
    endfunction

    function automatic t_date_beat rand_valid_date();
        return mk_date($urandom_range(ctu_pkg::YearFirst, ctu_pkg::YearLast),
                       $urandom_range(1, 12),
                       $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                       $urandom_range(0, 59), $urandom_range(0, 999));
    endfunction

    // each field: mostly valid, sometimes just past its limit, sometimes any bits
    function automatic t_date_beat rand_noisy_date();
        t_date_beat b;
        int sel;
        b = rand_valid_date();
        sel = $urandom_range(0, 15);
        if (sel == 0) b.year = 14'($urandom);
        else if (sel == 1) b.year = ($urandom_range(0, 1)) ? 14'd1969 : 14'd10000;
        sel = $urandom_range(0, 15);
        if (sel == 0) b.month = 7'($urandom);
        else if (sel == 1) b.month = ($urandom_range(0, 1)) ? 7'd0 : 7'd13;
        sel = $urandom_range(0, 15);
        if (sel == 0) b.day = 7'($urandom);
        else if (sel == 1) b.day = ($urandom_range(0, 1)) ? 7'd0 : 7'd32;
        sel = $urandom_range(0, 15);
        if (sel == 0) b.hour = 7'($urandom);
        else if (sel == 1) b.hour = 7'd24;
        sel = $urandom_range(0, 15);
        if (sel == 0) b.minute = 7'($urandom);
        else if (sel == 1) b.minute = 7'd60;
        sel = $urandom_range(0, 15);
        if (sel == 0) b.second = 7'($urandom);
        else if (sel == 1) b.second = 7'd60;
        sel = $urandom_range(0, 15);
        if (sel == 0) b.millis = 10'($urandom);
        else if (sel == 1) b.millis = 10'd1000;
        return b;
    endfunction

    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            idle_for($urandom_range(1, 7));
        end
    endtask

    task automatic send_date(input t_date_beat b);
        @(negedge i_clk);
        start = 1'b1;
        i_year = b.year;
        i_month = b.month;
        i_day = b.day;
        i_hour = b.hour;
        i_minute = b.minute;
        i_second = b.second;
        i_millis = b.millis;
        do @(posedge i_clk); while (busy);
        pending_stamps.push_back(predict_stamp(b));
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (pending_stamps.size() != 0 && n < DrainLimit) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic test_directed();
        t_date_beat list[$];
        list.push_back(mk_date(1970, 1, 1, 0, 0, 0, 0));
        list.push_back(mk_date(9999, 12, 31, 23, 59, 59, 999));
        list.push_back(mk_date(1969, 12, 31, 23, 59, 59, 999));
        list.push_back(mk_date(10000, 1, 1, 0, 0, 0, 0));
        list.push_back(mk_date(0, 1, 1, 0, 0, 0, 0));
        list.push_back(mk_date(16383, 127, 127, 127, 127, 127, 1023));
        list.push_back(mk_date(2000, 0, 1, 0, 0, 0, 0));
        list.push_back(mk_date(2000, 13, 1, 0, 0, 0, 0));
        list.push_back(mk_date(2000, 1, 0, 0, 0, 0, 0));
        list.push_back(mk_date(2000, 1, 32, 0, 0, 0, 0));
        list.push_back(mk_date(2000, 1, 1, 24, 0, 0, 0));
        list.push_back(mk_date(2000, 1, 1, 0, 60, 0, 0));
        list.push_back(mk_date(2000, 1, 1, 0, 0, 60, 0));
        list.push_back(mk_date(2000, 1, 1, 0, 0, 0, 1000));
        // leap rules: by 400, by 100, by 4
        list.push_back(mk_date(2000, 2, 29, 12, 0, 0, 0));
        list.push_back(mk_date(2000, 3, 1, 0, 0, 0, 0));
        list.push_back(mk_date(2100, 3, 1, 0, 0, 0, 0));
        list.push_back(mk_date(2400, 3, 1, 0, 0, 0, 0));
        list.push_back(mk_date(2024, 12, 31, 0, 0, 0, 1));
        // day past month end runs on into the next month
        list.push_back(mk_date(2023, 2, 31, 0, 0, 0, 0));
        list.push_back(mk_date(2024, 4, 31, 23, 59, 59, 0));
        list.push_back(mk_date(2038, 1, 19, 3, 14, 8, 0));
        foreach (list[i]) begin
            maybe_gap();
            send_date(list[i]);
        end
    endtask

    task automatic test_random_valid(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) gaps_on = $urandom_range(0, 1);
            maybe_gap();
            send_date(rand_valid_date());
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++) begin
            send_date(rand_valid_date());
        end
        @(negedge i_clk);
        start = 1'b0;
        wait_drained();
        for (int i = 0; i < 10; i++) begin
            send_date(rand_noisy_date());
        end
    endtask

    task automatic test_random_noisy(input int count);
        for (int i = 0; i < count; i++) begin
            maybe_gap();
            send_date(rand_noisy_date());
        end
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_date(($urandom_range(0, 3) == 0) ? rand_noisy_date() : rand_valid_date());
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_stamp exp_stamp;
        if (i_rst_n && o_strobe) begin
            if (pending_stamps.size() == 0) begin
                $error("unexpected result beat: epoch_millis %0d rejected %0b",
                       o_epoch_millis, o_rejected);
                err_count++;
            end else begin
                exp_stamp = pending_stamps.pop_front();
                if (o_epoch_millis !== exp_stamp.epoch_millis) begin
                    $error("epoch_millis: expected %0d, got %0d",
                           exp_stamp.epoch_millis, o_epoch_millis);
                    err_count++;
                end
                if (o_rejected !== exp_stamp.rejected) begin
                    $error("rejected: expected %0b, got %0b", exp_stamp.rejected, o_rejected);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_year = '0;
        i_month = '0;
        i_day = '0;
        i_hour = '0;
        i_minute = '0;
        i_second = '0;
        i_millis = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_valid(600);
        test_drain_pause();
        test_random_noisy(480);
        test_back_to_back(300);

        wait_drained();
        repeat (TailCycles) @(posedge i_clk);
        if (pending_stamps.size() != 0) begin
            $error("%0d expected results never arrived", pending_stamps.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- calendar_to_unix_millis.f -----
hdl/ctu_pkg.sv
hdl/ctu_front.sv
hdl/ctu_fifo.sv
hdl/ctu_back.sv
hdl/calendar_to_unix_millis.sv
sim/tb_calendar_to_unix_millis.sv
